>>> rtl/topk_min_heap_tracker_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the top-k heap tracker engine
// ---------------------------------------------------------------------------
`ifndef TOPK_MIN_HEAP_TRACKER_MACROS_SVH
`define TOPK_MIN_HEAP_TRACKER_MACROS_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define TOPK_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define TOPK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/topk_pkg.sv
// ---------------------------------------------------------------------------
// topk_pkg
// Types and constants shared by the top-k heap tracker.
// ---------------------------------------------------------------------------
package topk_pkg;

	typedef enum logic [2:0] {
		ST_UPDATED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_REPLACED = 3'd2,
		ST_REJECTED = 3'd3,
		ST_READ     = 3'd4
	} status_t;

	typedef enum logic {
		OP_OFFER = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	localparam logic [6:0] CAP_RESET = 7'd64;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] count;
		logic [31:0] interval;
	} entry_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] key;
		logic [31:0] count;
		logic [31:0] interval;
		logic [5:0]  slot;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_t;

	typedef struct packed {
		status_t     status;
		logic        evicted_valid;
		logic [31:0] evicted_key;
		logic [31:0] evicted_count;
		logic        read_valid;
		logic [31:0] read_key;
		logic [31:0] read_count;
		logic [31:0] read_interval;
		logic [6:0]  fill_level;
	} result_t;

endpackage

>>> rtl/topk_ram.sv
// ---------------------------------------------------------------------------
// topk_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module topk_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/topk_front.sv
// ---------------------------------------------------------------------------
// topk_front
// Accepts requests, classifies them and queues them for the heap engine.
// ---------------------------------------------------------------------------
module topk_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [31:0]           key,
	input  logic [31:0]           count,
	input  logic [31:0]           interval,
	input  logic [5:0]            slot,
	output topk_pkg::queue_t      q,
	input  logic                  pop
);

	topk_pkg::item_t buf_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      used_q;
	logic            push;

	assign in_stall = (used_q == 2'd2);
	assign push     = in_valid && !in_stall;

	assign q.valid = (used_q != 2'd0);
	assign q.item  = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q].op       <= cmd ? topk_pkg::OP_READ : topk_pkg::OP_OFFER;
			buf_q[wr_ptr_q].key      <= key;
			buf_q[wr_ptr_q].count    <= count;
			buf_q[wr_ptr_q].interval <= interval;
			buf_q[wr_ptr_q].slot     <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && q.valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !(pop && q.valid)) begin
				used_q <= used_q + 2'd1;
			end else if (!push && pop && q.valid) begin
				used_q <= used_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/topk_engine.sv
// ---------------------------------------------------------------------------
// topk_engine
// Executes queued requests on the heap memory: key search, insert, root
// replace, sift down and sift up, slot read. Holds the result register.
// ---------------------------------------------------------------------------
`include "topk_min_heap_tracker_macros.svh"

module topk_engine #(
	parameter int CAPACITY = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [6:0]            cap_cfg,
	input  topk_pkg::queue_t      q,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output topk_pkg::result_t     res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int NW = AW + 2;
	localparam int FW = $clog2(CAPACITY + 1);
	localparam int CW = (FW > 7) ? FW : 7;
	localparam int SW = (FW > 6) ? FW : 6;

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_ROOT, S_ROOT_DEC, S_STEP, S_DEC,
		S_W1, S_W2, S_READ, S_READ_DEC, S_RESP
	} state_t;

	typedef enum logic [1:0] {
		M_DOWN_UP, M_DOWN, M_UP
	} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     scan_q;
	logic              chk_q;
	logic [AW-1:0]     chk_idx_q;
	logic [AW-1:0]     at_q;
	logic [AW-1:0]     par_q;
	logic [AW-1:0]     pick_q;
	logic              pick_r_q;
	logic [1:0]        ph_q;
	logic              out_valid_q;

	logic [31:0]       key_q;
	logic [31:0]       cnt_q;
	logic [31:0]       ivl_q;
	logic [5:0]        slot_q;
	topk_pkg::entry_t  ent_p_q;
	topk_pkg::entry_t  ent_l_q;
	topk_pkg::entry_t  ent_r_q;
	topk_pkg::result_t acc_q;
	topk_pkg::result_t out_q;

	logic              we;
	logic [AW-1:0]     waddr;
	topk_pkg::entry_t  wdata;
	logic [AW-1:0]     raddr;
	topk_pkg::entry_t  rdata;
	logic [$bits(topk_pkg::entry_t)-1:0] rdata_raw;

	logic [CW-1:0]     cap_c;
	logic              room_c;
	logic              hit_c;
	logic              scan_end_c;
	logic              slot_ok_c;
	logic [NW-1:0]     l_c;
	logic [NW-1:0]     r_c;
	logic              l_in_c;
	logic              r_in_c;
	logic              swap_c;
	logic              pick_r_c;
	topk_pkg::entry_t  ent_pick_c;
	topk_pkg::result_t acc_init_c;
	topk_pkg::result_t out_c;

	state_t            cont_state;
	mode_t             cont_mode;
	logic [AW-1:0]     cont_par;

	topk_ram #(
		.WIDTH($bits(topk_pkg::entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rdata = topk_pkg::entry_t'(rdata_raw);

	assign cap_c = (CW'(cap_cfg) > CW'(CAPACITY)) ? CW'(CAPACITY) : CW'(cap_cfg);
	assign room_c     = CW'(fill_q) < cap_c;
	assign hit_c      = chk_q && (rdata.key == key_q);
	assign scan_end_c = (scan_q == fill_q);
	assign slot_ok_c  = SW'(slot_q) < SW'(fill_q);

	// children of the current parent
	assign l_c    = NW'({par_q, 1'b1});
	assign r_c    = NW'({par_q, 1'b0}) + NW'(2);
	assign l_in_c = l_c < NW'(fill_q);
	assign r_in_c = r_c < NW'(fill_q);

	always_comb begin
		if (!r_in_c) begin
			swap_c   = l_in_c && (ent_l_q.count < ent_p_q.count);
			pick_r_c = 1'b0;
		end else begin
			swap_c   = (ent_l_q.count < ent_p_q.count) || (ent_r_q.count < ent_p_q.count);
			pick_r_c = !(ent_l_q.count < ent_r_q.count);
		end
	end

	assign ent_pick_c = pick_r_q ? ent_r_q : ent_l_q;

	always_comb begin
		acc_init_c        = '0;
		acc_init_c.status = (q.item.op == topk_pkg::OP_READ) ?
			topk_pkg::ST_READ : topk_pkg::ST_REJECTED;
		out_c             = acc_q;
		out_c.fill_level  = 7'(fill_q);
	end

	// where the sift goes after a step that swapped (W2) or stopped (DEC)
	always_comb begin
		cont_state = S_RESP;
		cont_mode  = mode_q;
		cont_par   = par_q;
		if (mode_q != M_UP) begin
			if (state_q == S_W2) begin
				cont_par   = pick_q;
				cont_state = S_STEP;
			end else if (mode_q == M_DOWN_UP) begin
				cont_mode = M_UP;
				if (at_q != '0) begin
					cont_par   = (at_q - AW'(1)) >> 1;
					cont_state = S_STEP;
				end
			end
		end else if (state_q == S_W2) begin
			if (par_q != '0) begin
				cont_par   = (par_q - AW'(1)) >> 1;
				cont_state = S_STEP;
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '{key: key_q, count: cnt_q, interval: ivl_q};
		raddr = '0;
		case (state_q)
			S_SEARCH: begin
				if (hit_c) begin
					we    = 1'b1;
					waddr = chk_idx_q;
				end else if (!scan_end_c) begin
					raddr = scan_q[AW-1:0];
				end else if (room_c) begin
					we    = 1'b1;
					waddr = fill_q[AW-1:0];
				end
			end
			S_ROOT_DEC: begin
				we = cnt_q > rdata.count;
			end
			S_STEP: begin
				case (ph_q)
					2'd0:    raddr = par_q;
					2'd1:    raddr = l_c[AW-1:0];
					default: raddr = r_c[AW-1:0];
				endcase
			end
			S_W1: begin
				we    = 1'b1;
				waddr = par_q;
				wdata = ent_pick_c;
			end
			S_W2: begin
				we    = 1'b1;
				waddr = pick_q;
				wdata = ent_p_q;
			end
			S_READ: begin
				raddr = AW'(slot_q);
			end
			default: begin
			end
		endcase
	end

	assign pop       = (state_q == S_IDLE) && q.valid;
	assign out_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q  <= q.item.key;
				cnt_q  <= q.item.count;
				ivl_q  <= q.item.interval;
				slot_q <= q.item.slot;
				acc_q  <= acc_init_c;
			end
			S_SEARCH: begin
				if (hit_c) begin
					acc_q.status <= topk_pkg::ST_UPDATED;
				end else if (scan_end_c && room_c) begin
					acc_q.status <= topk_pkg::ST_INSERTED;
				end
			end
			S_ROOT_DEC: begin
				if (cnt_q > rdata.count) begin
					acc_q.status        <= topk_pkg::ST_REPLACED;
					acc_q.evicted_valid <= 1'b1;
					acc_q.evicted_key   <= rdata.key;
					acc_q.evicted_count <= rdata.count;
				end
			end
			S_STEP: begin
				case (ph_q)
					2'd1:    ent_p_q <= rdata;
					2'd2:    ent_l_q <= rdata;
					2'd3:    ent_r_q <= rdata;
					default: begin
					end
				endcase
			end
			S_READ_DEC: begin
				acc_q.read_valid    <= 1'b1;
				acc_q.read_key      <= rdata.key;
				acc_q.read_count    <= rdata.count;
				acc_q.read_interval <= rdata.interval;
			end
			default: begin
			end
		endcase
		if (state_q == S_RESP && (!out_valid_q || !out_stall)) begin
			out_q <= out_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_UP;
			fill_q      <= '0;
			scan_q      <= '0;
			chk_q       <= 1'b0;
			chk_idx_q   <= '0;
			at_q        <= '0;
			par_q       <= '0;
			pick_q      <= '0;
			pick_r_q    <= 1'b0;
			ph_q        <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q.valid) begin
						scan_q  <= '0;
						chk_q   <= 1'b0;
						state_q <= (q.item.op == topk_pkg::OP_READ) ? S_READ : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (hit_c) begin
						at_q    <= chk_idx_q;
						par_q   <= chk_idx_q;
						mode_q  <= M_DOWN_UP;
						ph_q    <= 2'd0;
						state_q <= S_STEP;
					end else if (!scan_end_c) begin
						chk_q     <= 1'b1;
						chk_idx_q <= scan_q[AW-1:0];
						scan_q    <= scan_q + FW'(1);
					end else if (room_c) begin
						fill_q <= fill_q + FW'(1);
						mode_q <= M_UP;
						ph_q   <= 2'd0;
						if (fill_q != '0) begin
							par_q   <= (fill_q[AW-1:0] - AW'(1)) >> 1;
							state_q <= S_STEP;
						end else begin
							state_q <= S_RESP;
						end
					end else if (fill_q != '0) begin
						state_q <= S_ROOT;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_ROOT: begin
					state_q <= S_ROOT_DEC;
				end
				S_ROOT_DEC: begin
					if (cnt_q > rdata.count) begin
						mode_q  <= M_DOWN;
						par_q   <= '0;
						ph_q    <= 2'd0;
						state_q <= S_STEP;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_STEP: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (swap_c) begin
						pick_q   <= pick_r_c ? r_c[AW-1:0] : l_c[AW-1:0];
						pick_r_q <= pick_r_c;
						state_q  <= S_W1;
					end else begin
						state_q <= cont_state;
						mode_q  <= cont_mode;
						par_q   <= cont_par;
						ph_q    <= 2'd0;
					end
				end
				S_W1: begin
					state_q <= S_W2;
				end
				S_W2: begin
					state_q <= cont_state;
					mode_q  <= cont_mode;
					par_q   <= cont_par;
					ph_q    <= 2'd0;
				end
				S_READ: begin
					state_q <= slot_ok_c ? S_READ_DEC : S_RESP;
				end
				S_READ_DEC: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TOPK_ASSERT(a_fill_bound, 1'b1, fill_q <= FW'(CAPACITY), "fill level above capacity")
	`TOPK_ASSERT(a_evict_status, out_valid_q && out_q.evicted_valid, out_q.status == topk_pkg::ST_REPLACED, "eviction reported without root replace")
	`TOPK_ASSERT_NEXT(a_fill_grows, 1'b1, fill_q >= $past(fill_q), "fill level dropped")

endmodule

>>> rtl/topk_min_heap_tracker.sv
// ---------------------------------------------------------------------------
// topk_min_heap_tracker
// Top-k flow tracker kept as a binary min-heap ordered by count.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   cmd key count interval slot
//   out      output     out_valid / out_stall status evicted_* read_* fill_level
//   cfg      input      cfg_we                cfg_wdata (capacity in use)
//
// A read fetches the requested slot, then responds. An offer scans the heap
// memory one slot a cycle, then each sift level reads parent and children
// and writes two entries on a swap; the single RAM read port sets the pace.
// A two deep request queue keeps accepting while the engine is busy, and the
// result register holds while out_stall is high. Reset empties the heap.
// ---------------------------------------------------------------------------
module topk_min_heap_tracker #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] key,
	input  logic [31:0] count,
	input  logic [31:0] interval,
	input  logic [5:0]  slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        evicted_valid,
	output logic [31:0] evicted_key,
	output logic [31:0] evicted_count,
	output logic        read_valid,
	output logic [31:0] read_key,
	output logic [31:0] read_count,
	output logic [31:0] read_interval,
	output logic [6:0]  fill_level,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);

	logic [6:0]        capacity_q;
	topk_pkg::queue_t  q;
	logic              pop;
	topk_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= topk_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	topk_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.key     (key),
		.count   (count),
		.interval(interval),
		.slot    (slot),
		.q       (q),
		.pop     (pop)
	);

	topk_engine #(
		.CAPACITY(CAPACITY)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cap_cfg  (capacity_q),
		.q        (q),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.res      (res)
	);

	assign status        = res.status;
	assign evicted_valid = res.evicted_valid;
	assign evicted_key   = res.evicted_key;
	assign evicted_count = res.evicted_count;
	assign read_valid    = res.read_valid;
	assign read_key      = res.read_key;
	assign read_count    = res.read_count;
	assign read_interval = res.read_interval;
	assign fill_level    = res.fill_level;

endmodule
